/* sv/r2p_pkg.sv */
// Shared types, widths and the arctangent table of the rectangular to polar converter.
package r2p_pkg;

  // field widths
  localparam int COORD_W   = 16;
  localparam int MAG_W     = 18;
  localparam int ANG_W     = 17;
  localparam int ANG_FRAC  = 8;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 40;

  // angle datapath: vector prescaled by 2^PRESCALE, accumulator in 2^-24 degree
  localparam int PRESCALE  = 60 - COORD_W;
  localparam int VEC_W     = 62;
  localparam int ACC_FRAC  = 24;
  localparam int Z_W       = 34;
  localparam int ITERS     = 28;
  localparam int IDX_W     = 5;
  localparam int ANG_SHIFT = ACC_FRAC - ANG_FRAC;

  // magnitude datapath: digit-by-digit root of x*x+y*y
  localparam int SQ_W      = 2 * COORD_W - 1;
  localparam int N_W       = 2 * COORD_W;
  localparam int ROOT_W    = 19;
  localparam int REM_W     = 22;
  localparam int ROOT_STEPS = 19;
  localparam int MAG_DLY   = ITERS - ROOT_STEPS - 1;

  // angle constants
  localparam logic signed [Z_W-1:0]   Z_DEG90  = Z_W'(90 * (2 ** ACC_FRAC));
  localparam logic signed [Z_W-1:0]   Z_HALF   = Z_W'(2 ** (ANG_SHIFT - 1));
  localparam logic signed [ANG_W:0]   ANG_LIM  = (ANG_W + 1)'(180 * (2 ** ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_180  = ANG_W'(180 * (2 ** ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_90   = ANG_W'(90 * (2 ** ANG_FRAC));
  localparam logic [MAG_W-1:0]        MAG_MAX  = '1;

  // which answer the angle takes
  typedef enum logic [4:0] {
    KIND_CORDIC = 5'b00001,
    KIND_ZERO   = 5'b00010,
    KIND_NEG_X  = 5'b00100,
    KIND_POS_Y  = 5'b01000,
    KIND_NEG_Y  = 5'b10000
  } kind_t;

  // word handed between CORDIC cells
  typedef struct packed {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [Z_W-1:0]   z;
    kind_t                   kind;
  } cordic_t;

  // word handed between square root cells
  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
    case (idx)
      5'd0:    atan_deg = 34'sd754974720;
      5'd1:    atan_deg = 34'sd445687602;
      5'd2:    atan_deg = 34'sd235489088;
      5'd3:    atan_deg = 34'sd119537938;
      5'd4:    atan_deg = 34'sd60000934;
      5'd5:    atan_deg = 34'sd30029717;
      5'd6:    atan_deg = 34'sd15018523;
      5'd7:    atan_deg = 34'sd7509720;
      5'd8:    atan_deg = 34'sd3754917;
      5'd9:    atan_deg = 34'sd1877466;
      5'd10:   atan_deg = 34'sd938734;
      5'd11:   atan_deg = 34'sd469367;
      5'd12:   atan_deg = 34'sd234684;
      5'd13:   atan_deg = 34'sd117342;
      5'd14:   atan_deg = 34'sd58671;
      5'd15:   atan_deg = 34'sd29335;
      5'd16:   atan_deg = 34'sd14668;
      5'd17:   atan_deg = 34'sd7334;
      5'd18:   atan_deg = 34'sd3667;
      5'd19:   atan_deg = 34'sd1833;
      5'd20:   atan_deg = 34'sd917;
      5'd21:   atan_deg = 34'sd458;
      5'd22:   atan_deg = 34'sd229;
      5'd23:   atan_deg = 34'sd115;
      5'd24:   atan_deg = 34'sd57;
      5'd25:   atan_deg = 34'sd29;
      5'd26:   atan_deg = 34'sd14;
      5'd27:   atan_deg = 34'sd7;
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

/* sv/r2p_prep.sv */
// Input stage: quadrant pre-rotation, axis classification and coordinate squares.
module r2p_prep (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [r2p_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [r2p_pkg::COORD_W-1:0]  y_coord,
  output r2p_pkg::cordic_t                    vec,
  output logic [r2p_pkg::SQ_W-1:0]            xx,
  output logic [r2p_pkg::SQ_W-1:0]            yy
);

  localparam int EXT_W = r2p_pkg::COORD_W + 1;

  logic signed [EXT_W-1:0]                 x_ext, y_ext, vx_ext, vy_ext;
  logic signed [r2p_pkg::Z_W-1:0]          z_init;
  logic signed [2*r2p_pkg::COORD_W-1:0]    x_sq, y_sq;
  r2p_pkg::kind_t                          kind;
  r2p_pkg::cordic_t                        vec_next;

  assign x_ext = {x_coord[r2p_pkg::COORD_W-1], x_coord};
  assign y_ext = {y_coord[r2p_pkg::COORD_W-1], y_coord};
  assign x_sq  = x_coord * x_coord;
  assign y_sq  = y_coord * y_coord;

  // left half plane is turned by 90 degrees toward the right half
  always_comb begin
    if (x_coord[r2p_pkg::COORD_W-1]) begin
      if (!y_coord[r2p_pkg::COORD_W-1]) begin
        vx_ext = y_ext;
        vy_ext = -x_ext;
        z_init = r2p_pkg::Z_DEG90;
      end else begin
        vx_ext = -y_ext;
        vy_ext = x_ext;
        z_init = -r2p_pkg::Z_DEG90;
      end
    end else begin
      vx_ext = x_ext;
      vy_ext = y_ext;
      z_init = '0;
    end
  end

  // points on an axis get an exact angle
  always_comb begin
    if (y_coord == '0) begin
      kind = x_coord[r2p_pkg::COORD_W-1] ? r2p_pkg::KIND_NEG_X : r2p_pkg::KIND_ZERO;
    end else if (x_coord == '0) begin
      kind = y_coord[r2p_pkg::COORD_W-1] ? r2p_pkg::KIND_NEG_Y : r2p_pkg::KIND_POS_Y;
    end else begin
      kind = r2p_pkg::KIND_CORDIC;
    end
  end

  always_comb begin
    vec_next.vx   = {{(r2p_pkg::VEC_W-EXT_W){vx_ext[EXT_W-1]}}, vx_ext} <<< r2p_pkg::PRESCALE;
    vec_next.vy   = {{(r2p_pkg::VEC_W-EXT_W){vy_ext[EXT_W-1]}}, vy_ext} <<< r2p_pkg::PRESCALE;
    vec_next.z    = z_init;
    vec_next.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec <= vec_next;
      xx  <= x_sq[r2p_pkg::SQ_W-1:0];
      yy  <= y_sq[r2p_pkg::SQ_W-1:0];
    end
  end

endmodule

/* sv/r2p_cordic_cell.sv */
// One CORDIC vectoring iteration: rotate toward the x axis and accumulate the angle.
module r2p_cordic_cell (
  input  logic                            clk,
  input  logic                            load,
  input  logic [r2p_pkg::IDX_W-1:0]       idx,
  input  r2p_pkg::cordic_t                vec_in,
  output r2p_pkg::cordic_t                vec_out
);

  logic signed [r2p_pkg::VEC_W-1:0] vx, vy, dx, dy;
  logic signed [r2p_pkg::Z_W-1:0]   z, da;
  r2p_pkg::cordic_t                 vec_next;

  assign vx = vec_in.vx;
  assign vy = vec_in.vy;
  assign z  = vec_in.z;
  // floor shifts
  assign dx = vy >>> idx;
  assign dy = vx >>> idx;
  assign da = r2p_pkg::atan_deg(idx);

  // rotation direction from the sign of y
  always_comb begin
    vec_next.kind = vec_in.kind;
    if (!vy[r2p_pkg::VEC_W-1]) begin
      vec_next.vx = vx + dx;
      vec_next.vy = vy - dy;
      vec_next.z  = z + da;
    end else begin
      vec_next.vx = vx - dx;
      vec_next.vy = vy + dy;
      vec_next.z  = z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec_out <= vec_next;
    end
  end

endmodule

/* sv/r2p_sqrt_cell.sv */
// One step of the digit-by-digit square root: one radicand bit pair, one root bit.
module r2p_sqrt_cell (
  input  logic            clk,
  input  logic            load,
  input  r2p_pkg::sqrt_t  sq_in,
  output r2p_pkg::sqrt_t  sq_out
);

  logic [r2p_pkg::REM_W-1:0] rem_sh, trial;
  r2p_pkg::sqrt_t            sq_next;

  // bring down the next pair from the top of the radicand
  assign rem_sh = {sq_in.rem[r2p_pkg::REM_W-3:0], sq_in.n[r2p_pkg::N_W-1 -: 2]};
  assign trial  = r2p_pkg::REM_W'({sq_in.root, 2'b01});

  always_comb begin
    sq_next.n = {sq_in.n[r2p_pkg::N_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_next.rem  = rem_sh - trial;
      sq_next.root = {sq_in.root[r2p_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      sq_next.rem  = rem_sh;
      sq_next.root = {sq_in.root[r2p_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sq_out <= sq_next;
    end
  end

endmodule

/* sv/rect_to_polar_converter.sv */
// Top level: rectangular to polar converter built from a row of CORDIC and root cells.
//
// Input stream (s_*): one point per word, x_coord and y_coord as signed integers.
// Output stream (m_*): one word per point, magnitude (unsigned, 2 fractional bits,
// rounded to nearest) and angle_degrees (signed, 8 fractional bits, -180..+180).
// Results leave in the order the points arrived.
// Throughput: one point per cycle while the skid is empty; each stage is one cell register.
// Path: the input stage loads a point at the edge that accepts it, then the result
// passes 28 CORDIC cells and one output register before it shows on m_tvalid. The
// magnitude runs in a parallel row of 19 root cells, padded with delay registers to
// the same length.
// Reset clears all stage valid bits and the valid bits of the output and skid registers;
// no result is pending afterward and s_tready is high.
// Stall: when m_tready is low the output holds; the next result falls into a skid
// register, after which the whole row and s_tready hold until the output drains.
module rect_to_polar_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [r2p_pkg::TDATA_IN_W-1:0]      s_tdata,  // x_coord[15:0], y_coord[31:16]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [r2p_pkg::TDATA_OUT_W-1:0]     m_tdata   // magnitude[17:0], angle_degrees[34:18]
);

  localparam int NSTG = r2p_pkg::ITERS + 1;
  localparam int PAD_W = r2p_pkg::TDATA_OUT_W - r2p_pkg::MAG_W - r2p_pkg::ANG_W;

  logic                                en;
  logic [NSTG-1:0]                     vld;
  r2p_pkg::cordic_t                    vec [0:r2p_pkg::ITERS];
  r2p_pkg::sqrt_t                      sq  [0:r2p_pkg::ROOT_STEPS];
  r2p_pkg::sqrt_t                      sq_head;
  logic [r2p_pkg::SQ_W-1:0]            xx, yy;
  logic [r2p_pkg::ROOT_W-1:0]          mag_dly [0:r2p_pkg::MAG_DLY-1];

  logic signed [r2p_pkg::Z_W-1:0]      z_rnd;
  logic signed [r2p_pkg::ANG_W:0]      ang_full;
  logic signed [r2p_pkg::ANG_W-1:0]    ang;
  logic [r2p_pkg::ROOT_W:0]            mag_sum;
  logic [r2p_pkg::MAG_W-1:0]           mag;
  logic [r2p_pkg::TDATA_OUT_W-1:0]     word_next;

  logic                                skid_valid;
  logic [r2p_pkg::TDATA_OUT_W-1:0]     skid_data;

  // the row advances unless a result sits in the skid register
  assign en       = !skid_valid;
  assign s_tready = en;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  r2p_prep u_prep (
    .clk     (clk),
    .load    (en),
    .x_coord (s_tdata[r2p_pkg::COORD_W-1:0]),
    .y_coord (s_tdata[2*r2p_pkg::COORD_W-1:r2p_pkg::COORD_W]),
    .vec     (vec[0]),
    .xx      (xx),
    .yy      (yy)
  );

  // angle row
  for (genvar i = 0; i < r2p_pkg::ITERS; i++) begin : g_cordic
    r2p_cordic_cell u_cell (
      .clk     (clk),
      .load    (en),
      .idx     (r2p_pkg::IDX_W'(i)),
      .vec_in  (vec[i]),
      .vec_out (vec[i+1])
    );
  end

  // radicand, alongside the first CORDIC cell
  always_ff @(posedge clk) begin
    if (en) begin
      sq_head.n    <= r2p_pkg::N_W'(xx) + r2p_pkg::N_W'(yy);
      sq_head.rem  <= '0;
      sq_head.root <= '0;
    end
  end

  assign sq[0] = sq_head;

  // magnitude row
  for (genvar j = 0; j < r2p_pkg::ROOT_STEPS; j++) begin : g_sqrt
    r2p_sqrt_cell u_cell (
      .clk    (clk),
      .load   (en),
      .sq_in  (sq[j]),
      .sq_out (sq[j+1])
    );
  end

  // pad the root to the length of the angle row
  always_ff @(posedge clk) begin
    if (en) begin
      mag_dly[0] <= sq[r2p_pkg::ROOT_STEPS].root;
      for (int k = 1; k < r2p_pkg::MAG_DLY; k++) begin
        mag_dly[k] <= mag_dly[k-1];
      end
    end
  end

  // round the root of 64*n to 2 fractional bits, saturate
  assign mag_sum = {1'b0, mag_dly[r2p_pkg::MAG_DLY-1]} + (r2p_pkg::ROOT_W+1)'(1);
  assign mag = (mag_sum[r2p_pkg::ROOT_W:r2p_pkg::MAG_W+1] != '0) ? r2p_pkg::MAG_MAX
             : mag_sum[r2p_pkg::MAG_W:1];

  // round the accumulator to 8 fractional bits
  assign z_rnd    = vec[r2p_pkg::ITERS].z + r2p_pkg::Z_HALF;
  assign ang_full = z_rnd[r2p_pkg::Z_W-1 -: (r2p_pkg::ANG_W + 1)];

  always_comb begin
    case (vec[r2p_pkg::ITERS].kind)
      r2p_pkg::KIND_ZERO:  ang = '0;
      r2p_pkg::KIND_NEG_X: ang = r2p_pkg::ANG_180;
      r2p_pkg::KIND_POS_Y: ang = r2p_pkg::ANG_90;
      r2p_pkg::KIND_NEG_Y: ang = -r2p_pkg::ANG_90;
      r2p_pkg::KIND_CORDIC: begin
        if (ang_full > r2p_pkg::ANG_LIM) begin
          ang = r2p_pkg::ANG_180;
        end else if (ang_full < -r2p_pkg::ANG_LIM) begin
          ang = -r2p_pkg::ANG_180;
        end else begin
          ang = ang_full[r2p_pkg::ANG_W-1:0];
        end
      end
      default: ang = '0;
    endcase
  end

  assign word_next = {{PAD_W{1'b0}}, ang, mag};

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || (en && vld[NSTG-1]);
      skid_valid <= 1'b0;
    end else if (en && vld[NSTG-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : word_next;
    end else if (en && vld[NSTG-1]) begin
      skid_data <= word_next;
    end
  end

endmodule

/* bench/r2p_polar_checker.sv */
// Checker for the rectangular to polar converter: watches both streams and compares results.
`timescale 1ns / 100ps

module r2p_polar_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [r2p_pkg::TDATA_IN_W-1:0]      s_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [r2p_pkg::TDATA_OUT_W-1:0]     m_tdata,   // magnitude[17:0], angle_degrees[34:18]
  output int                                  mismatches,
  output int                                  outstanding
);

  import r2p_pkg::*;

  // predicted result word
  typedef struct packed {
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } polar_t;

  localparam int SCALE_SH  = 60 - COORD_W;   // vector prescale
  localparam int Z_FRAC    = 24;             // accumulator fraction bits
  localparam int ROUND_SH  = Z_FRAC - ANG_FRAC;
  localparam longint ANGLE_180 = 180 * 256;
  localparam longint ANGLE_90  = 90 * 256;

  // atan(2^-i) in 2^-24 degree
  localparam longint ATAN_STEP [28] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7
  };

  polar_t polar_due[$];

  // magnitude by exact root, angle by vectoring rotations
  function automatic polar_t to_polar(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y);
    longint signed   xs, ys, vx, vy, z, dx, dy, t, ang;
    longint unsigned sum, rem, root, pair, trial, mag;
    polar_t p;
    xs = x;
    ys = y;
    sum = longint'(xs * xs + ys * ys);

    // floor(8*sqrt(sum)), then halve with rounding
    rem = 0;
    root = 0;
    for (int k = 34; k >= 0; k--) begin
      pair = (k >= 3) ? ((sum >> (2 * (k - 3))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    mag = (root + 1) >> 1;
    if (mag > 64'(MAG_MAX)) mag = 64'(MAG_MAX);
    p.mag = mag[MAG_W-1:0];

    if (y == 0) begin
      ang = (x < 0) ? ANGLE_180 : 0;
    end else if (x == 0) begin
      ang = (y > 0) ? ANGLE_90 : -ANGLE_90;
    end else begin
      vx = xs <<< SCALE_SH;
      vy = ys <<< SCALE_SH;
      z = 0;
      // left half plane: quarter turn first
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx = vy;
          vy = -t;
          z = 90 * (longint'(1) <<< Z_FRAC);
        end else begin
          vx = -vy;
          vy = t;
          z = -90 * (longint'(1) <<< Z_FRAC);
        end
      end
      for (int i = 0; i < 28; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          z = z + ATAN_STEP[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          z = z - ATAN_STEP[i];
        end
      end
      ang = (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
      if (ang > ANGLE_180) ang = ANGLE_180;
      if (ang < -ANGLE_180) ang = -ANGLE_180;
    end
    p.ang = ang[ANG_W-1:0];
    return p;
  endfunction

  task automatic log_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // compare outgoing words, then queue predictions for incoming ones
  always @(posedge clk) begin
    polar_t want;
    if (rst) begin
      polar_due.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (polar_due.size() == 0) begin
          log_mismatch($sformatf("result word with nothing pending, data %h", m_tdata));
        end else begin
          want = polar_due.pop_front();
          if (m_tdata[MAG_W-1:0] !== want.mag)
            log_mismatch($sformatf("magnitude %0d, predicted %0d",
                                   m_tdata[MAG_W-1:0], want.mag));
          if (m_tdata[MAG_W+ANG_W-1:MAG_W] !== want.ang)
            log_mismatch($sformatf("angle %0d, predicted %0d",
                                   $signed(m_tdata[MAG_W+ANG_W-1:MAG_W]), want.ang));
        end
      end
      if (s_tvalid && s_tready)
        polar_due.push_back(to_polar(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W]));
    end
    outstanding <= polar_due.size();
  end

endmodule

/* bench/tb_rect_to_polar_converter.sv */
// Testbench top for the rectangular to polar converter: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_rect_to_polar_converter;

  import r2p_pkg::*;

  localparam int RANDOM_POINTS = 1800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_AT_WORD  = 300;
  localparam int HOLD_CYCLES   = 400;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata;   // x_coord[15:0], y_coord[31:16]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;   // magnitude[17:0], angle_degrees[34:18]

  int  mismatches;
  int  outstanding;
  int  cycles;
  bit  sender_steady;
  bit  receiver_steady;

  rect_to_polar_converter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  r2p_polar_checker polar_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rect_to_polar_converter test failed");
      $finish;
    end
  end

  // offer one point; the word is taken at an edge with s_tready high
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    int gap;
    if ($urandom_range(0, 49) == 0) sender_steady = ~sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_steady = ~receiver_steady;
      stall = receiver_steady ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AT_WORD) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int dir_x [20];
    int dir_y [20];
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;

    dir_x = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, -1,
              1, 0, 0, -1, -1, 1, 1, -32768, -32768, -5};
    dir_y = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0,
              0, 1, -1, 1, -1, -1, 1, 1, -1, 3};
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cycles   = 0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners, axes and the points next to the branch cut
    foreach (dir_x[i]) send_point(dir_x[i][COORD_W-1:0], dir_y[i][COORD_W-1:0]);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      case ($urandom_range(0, 7))
        4: begin
          x = COORD_W'(int'($urandom_range(0, 64)) - 32);
          y = COORD_W'(int'($urandom_range(0, 64)) - 32);
        end
        5: begin
          x = COORD_W'($urandom);
          y = 0;
          if ($urandom_range(0, 1)) begin
            y = x;
            x = 0;
          end
        end
        6: begin
          x = COORD_W'(-int'($urandom_range(1, 32768)));
          y = COORD_W'(int'($urandom_range(0, 4)) - 2);
        end
        7: begin
          x = COORD_W'($urandom);
          y = $urandom_range(0, 1) ? x : -x;
        end
        default: begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
      endcase
      send_point(x, y);
    end
    s_tvalid <= 1'b0;

    // drain
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("rect_to_polar_converter test passed");
    end else begin
      $display("rect_to_polar_converter test failed");
    end
    $finish;
  end

endmodule
